>>> hw/rtl/lat_pkg.sv
// ----------------------------------------------------------------------------
// lat_pkg
// Shared types, latencies and helpers for the look-at to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lat_pkg;

  localparam int COORD_WIDTH = 32;

  // Stage counts of the pipelined units.
  localparam int BS_LAT    = 3;
  localparam int ISQ_LAT   = 32;
  localparam int DIV_LAT   = 31;
  localparam int UNIT_LAT  = 2 + ISQ_LAT + 1 + DIV_LAT + 1;
  localparam int CROSS_LAT = 2;
  localparam int TOTAL_LAT = 1 + BS_LAT + UNIT_LAT + CROSS_LAT + BS_LAT + UNIT_LAT
                             + 2 + 1 + ISQ_LAT + 1 + DIV_LAT + 1;

  localparam logic [34:0] ONE_Q30 = 35'd1 << 30;

  typedef logic [2:0][63:0] wvec_t;  // wide two's complement components
  typedef logic [2:0][30:0] svec_t;  // block-scaled components, |c| < 2^30
  typedef logic [2:0][31:0] uvec_t;  // unit vector components, Q2.30

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] eye_x;
    logic signed [COORD_WIDTH-1:0] eye_y;
    logic signed [COORD_WIDTH-1:0] eye_z;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic signed [COORD_WIDTH-1:0] target_z;
    logic signed [COORD_WIDTH-1:0] up_x;
    logic signed [COORD_WIDTH-1:0] up_y;
    logic signed [COORD_WIDTH-1:0] up_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               degenerate;
  } out_t;

  // Position of the highest set bit; zero for a zero word.
  function automatic logic [5:0] msb_pos(input logic [62:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 63; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lat_isqrt.sv
// ----------------------------------------------------------------------------
// lat_isqrt
// Pipelined integer square root, floor(sqrt(n)) of a 64-bit word, one result
// bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_in,
  output logic [31:0] root
);

  logic [63:0] n_r   [lat_pkg::ISQ_LAT];
  logic [63:0] res_r [lat_pkg::ISQ_LAT];

  for (genvar k = 0; k < lat_pkg::ISQ_LAT; k++) begin : g_st
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] n_p, res_p, trial;
    if (k == 0) begin : g_first
      assign n_p   = n_in;
      assign res_p = '0;
    end else begin : g_next
      assign n_p   = n_r[k-1];
      assign res_p = res_r[k-1];
    end
    assign trial = res_p + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_p >= trial) begin
          n_r[k]   <= n_p - trial;
          res_r[k] <= (res_p >> 1) + BIT;
        end else begin
          n_r[k]   <= n_p;
          res_r[k] <= res_p >> 1;
        end
      end
    end
  end

  assign root = res_r[lat_pkg::ISQ_LAT-1][31:0];

endmodule

`default_nettype wire

>>> hw/rtl/lat_div.sv
// ----------------------------------------------------------------------------
// lat_div
// Pipelined restoring divider: 62-bit dividend, 32-bit divisor, 31-bit
// quotient, one quotient bit per stage. The quotient must fit in 31 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_div (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] num,
  input  logic [31:0] den,
  output logic [30:0] q
);

  logic [61:0] rem_r [lat_pkg::DIV_LAT];
  logic [31:0] den_r [lat_pkg::DIV_LAT];
  logic [30:0] q_r   [lat_pkg::DIV_LAT];

  for (genvar k = 0; k < lat_pkg::DIV_LAT; k++) begin : g_st
    localparam int J = lat_pkg::DIV_LAT - 1 - k;
    logic [61:0] rem_p;
    logic [31:0] den_p;
    logic [30:0] q_p;
    logic [62:0] sub;
    if (k == 0) begin : g_first
      assign rem_p = num;
      assign den_p = den;
      assign q_p   = '0;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign den_p = den_r[k-1];
      assign q_p   = q_r[k-1];
    end
    assign sub = {31'd0, den_p} << J;
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_p;
        if ({1'b0, rem_p} >= sub) begin
          rem_r[k] <= rem_p - sub[61:0];
          q_r[k]   <= q_p | (31'd1 << J);
        end else begin
          rem_r[k] <= rem_p;
          q_r[k]   <= q_p;
        end
      end
    end
  end

  assign q = q_r[lat_pkg::DIV_LAT-1];

endmodule

`default_nettype wire

>>> hw/rtl/lat_bscale.sv
// ----------------------------------------------------------------------------
// lat_bscale
// Block scaling of a three-component vector: shifts all components by one
// power of two so that the largest magnitude lies in [2^29, 2^30).
// ----------------------------------------------------------------------------
`default_nettype none

module lat_bscale (
  input  logic            clk,
  input  logic            en,
  input  lat_pkg::wvec_t  v_in,
  output lat_pkg::svec_t  v_out,
  output logic            nz
);

  logic [2:0][62:0] mag_c, mag_r, mag2_r, sh_c;
  logic [2:0]       neg_r, neg2_r;
  logic [62:0]      or_r;
  logic [5:0]       pos_r;
  logic             nz2_r, nz3_r;
  lat_pkg::svec_t   v_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = v_in[i][63] ? (~v_in[i][62:0] + 63'd1) : v_in[i][62:0];
    end
  end

  // The top bit of the OR of the magnitudes is the top bit of the largest one.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos_r >= 6'd30) begin
        sh_c[i] = mag2_r[i] >> (pos_r - 6'd29);
      end else begin
        sh_c[i] = mag2_r[i] << (6'd29 - pos_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= mag_c;
      neg_r  <= {v_in[2][63], v_in[1][63], v_in[0][63]};
      or_r   <= mag_c[0] | mag_c[1] | mag_c[2];
      mag2_r <= mag_r;
      neg2_r <= neg_r;
      pos_r  <= lat_pkg::msb_pos(or_r);
      nz2_r  <= |or_r;
      nz3_r  <= nz2_r;
      for (int i = 0; i < 3; i++) begin
        v_r[i] <= neg2_r[i] ? (~{1'b0, sh_c[i][29:0]} + 31'd1) : {1'b0, sh_c[i][29:0]};
      end
    end
  end

  assign v_out = v_r;
  assign nz    = nz3_r;

endmodule

`default_nettype wire

>>> hw/rtl/lat_unit.sv
// ----------------------------------------------------------------------------
// lat_unit
// Normalizes a block-scaled vector to a Q2.30 unit vector: sum of squares,
// pipelined root, then a rounded division of each component by the length.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_unit (
  input  logic            clk,
  input  logic            en,
  input  lat_pkg::svec_t  v_in,
  output lat_pkg::uvec_t  u_out
);

  logic [2:0][29:0] mag_c, mag_r, mag2_r;
  logic [2:0]       neg_r, neg2_r, neg3_r;
  logic [59:0]      sq_r [3];
  logic [61:0]      sum_r;
  logic [31:0]      len;
  logic [2:0][29:0] mag_dl_r [lat_pkg::ISQ_LAT];
  logic [2:0]       neg_dl_r [lat_pkg::ISQ_LAT];
  logic [2:0]       negq_dl_r [lat_pkg::DIV_LAT];
  logic [61:0]      num_r [3];
  logic [31:0]      den_r;
  logic [30:0]      q [3];
  lat_pkg::uvec_t   u_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = v_in[i][30] ? (~v_in[i][29:0] + 30'd1) : v_in[i][29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= mag_c[i] * mag_c[i];
      end
      mag_r  <= mag_c;
      neg_r  <= {v_in[2][30], v_in[1][30], v_in[0][30]};
      sum_r  <= 62'(sq_r[0]) + 62'(sq_r[1]) + 62'(sq_r[2]);
      mag2_r <= mag_r;
      neg2_r <= neg_r;
      mag_dl_r[0] <= mag2_r;
      neg_dl_r[0] <= neg2_r;
      for (int k = 1; k < lat_pkg::ISQ_LAT; k++) begin
        mag_dl_r[k] <= mag_dl_r[k-1];
        neg_dl_r[k] <= neg_dl_r[k-1];
      end
      // Rounded quotient: add half the divisor before dividing.
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= {2'b00, mag_dl_r[lat_pkg::ISQ_LAT-1][i], 30'd0} + 62'(len[31:1]);
      end
      den_r  <= len;
      neg3_r <= neg_dl_r[lat_pkg::ISQ_LAT-1];
      negq_dl_r[0] <= neg3_r;
      for (int k = 1; k < lat_pkg::DIV_LAT; k++) begin
        negq_dl_r[k] <= negq_dl_r[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= negq_dl_r[lat_pkg::DIV_LAT-1][i] ? (~{1'b0, q[i]} + 32'd1) : {1'b0, q[i]};
      end
    end
  end

  lat_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .n_in ({2'b00, sum_r}),
    .root (len)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    lat_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[i]),
      .den (den_r),
      .q   (q[i])
    );
  end

  assign u_out = u_r;

endmodule

`default_nettype wire

>>> hw/rtl/look_at_to_quaternion.sv
// ----------------------------------------------------------------------------
// look_at_to_quaternion
// Builds the look-at basis from eye, target and up points and converts it to
// a saturated Q2.14 quaternion by the four-branch trace method.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | input     | in_t:  eye, target, up (Q16.16)
//  out_    | output    | out_t: quat_x/y/z/w (Q2.14), degenerate
//
// One transfer per cycle on each side while no finished result is held by out_stall;
// the path runs through three pipelined root units and three divider banks.
// Reset clears only the valid bits of the pipeline.
// While a result waits with out_stall high, every stage holds and in_stall
// is raised; bubbles move forward otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_to_quaternion (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lat_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lat_pkg::out_t out_data
);

  localparam int FL = lat_pkg::CROSS_LAT + lat_pkg::BS_LAT + lat_pkg::UNIT_LAT;

  typedef enum logic [1:0] {BR_W, BR_X, BR_Y, BR_Z} br_t;

  typedef struct packed {
    br_t              br;
    logic             deg;
    logic [2:0][33:0] d;
  } root_side_t;

  typedef struct packed {
    br_t        br;
    logic       deg;
    logic [2:0] neg;
    logic [15:0] diag;
  } div_side_t;

  logic                     en;
  logic [lat_pkg::TOTAL_LAT-1:0] vld_r;

  logic signed [63:0] f_c [3];
  logic signed [63:0] u_c [3];
  lat_pkg::wvec_t     f_in_r, u_in_r;
  lat_pkg::svec_t     fs, us, rs;
  logic               fnz, unz, rnz;
  lat_pkg::uvec_t     fu, ru;

  lat_pkg::svec_t     us_dl_r   [lat_pkg::UNIT_LAT];
  logic               dega_dl_r [lat_pkg::UNIT_LAT];
  logic               rnz_dl_r  [lat_pkg::UNIT_LAT];
  lat_pkg::uvec_t     fu_dl_r   [FL];
  logic               degb_dl_r [FL];

  logic signed [62:0] xp_r [6];
  logic signed [63:0] rx_c [3];
  lat_pkg::wvec_t     r_r;

  logic signed [63:0] vp_r [6];
  lat_pkg::uvec_t     ff_r, rr_r;
  logic               deg1_r, deg2_r, deg_v;
  logic signed [63:0] vd_c [3];
  logic [63:0]        vm_c [3];
  logic [33:0]        vq_c [3];
  logic signed [31:0] m_r  [9];

  logic signed [34:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, t_c;
  logic signed [34:0] d_c [3];
  br_t                br_c;
  logic [63:0]        root_arg_r;
  root_side_t         ms_r;
  root_side_t         rs_dl_r [lat_pkg::ISQ_LAT];
  logic [31:0]        s;

  logic [32:0]        dmag_c [3];
  logic [32:0]        diag_c;
  logic [61:0]        num_r [3];
  logic [31:0]        den_r;
  div_side_t          cs_r;
  div_side_t          ds_dl_r [lat_pkg::DIV_LAT];
  logic [30:0]        q [3];
  logic [15:0]        off_c [3];
  lat_pkg::out_t      out_c, out_data_r;

  // Whole pipeline advances unless a finished result is held.
  assign en       = !(vld_r[lat_pkg::TOTAL_LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[lat_pkg::TOTAL_LAT-2:0], in_valid};
    end
  end

  assign f_c[0] = 64'(in_data.target_x) - 64'(in_data.eye_x);
  assign f_c[1] = 64'(in_data.target_y) - 64'(in_data.eye_y);
  assign f_c[2] = 64'(in_data.target_z) - 64'(in_data.eye_z);
  assign u_c[0] = 64'(in_data.up_x);
  assign u_c[1] = 64'(in_data.up_y);
  assign u_c[2] = 64'(in_data.up_z);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f_in_r[i] <= f_c[i];
        u_in_r[i] <= u_c[i];
      end
    end
  end

  lat_bscale u_bs_f (.clk(clk), .en(en), .v_in(f_in_r), .v_out(fs), .nz(fnz));
  lat_bscale u_bs_u (.clk(clk), .en(en), .v_in(u_in_r), .v_out(us), .nz(unz));
  lat_unit   u_unit_f (.clk(clk), .en(en), .v_in(fs), .u_out(fu));

  // Right vector: up x forward.
  always_comb begin
    rx_c[0] = 64'(xp_r[0]) - 64'(xp_r[1]);
    rx_c[1] = 64'(xp_r[2]) - 64'(xp_r[3]);
    rx_c[2] = 64'(xp_r[4]) - 64'(xp_r[5]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      us_dl_r[0]   <= us;
      dega_dl_r[0] <= !(fnz && unz);
      rnz_dl_r[0]  <= rnz;
      for (int k = 1; k < lat_pkg::UNIT_LAT; k++) begin
        us_dl_r[k]   <= us_dl_r[k-1];
        dega_dl_r[k] <= dega_dl_r[k-1];
        rnz_dl_r[k]  <= rnz_dl_r[k-1];
      end
      fu_dl_r[0]   <= fu;
      degb_dl_r[0] <= dega_dl_r[lat_pkg::UNIT_LAT-1];
      for (int k = 1; k < FL; k++) begin
        fu_dl_r[k]   <= fu_dl_r[k-1];
        degb_dl_r[k] <= degb_dl_r[k-1];
      end
      xp_r[0] <= $signed(us_dl_r[lat_pkg::UNIT_LAT-1][1]) * $signed(fu[2]);
      xp_r[1] <= $signed(us_dl_r[lat_pkg::UNIT_LAT-1][2]) * $signed(fu[1]);
      xp_r[2] <= $signed(us_dl_r[lat_pkg::UNIT_LAT-1][2]) * $signed(fu[0]);
      xp_r[3] <= $signed(us_dl_r[lat_pkg::UNIT_LAT-1][0]) * $signed(fu[2]);
      xp_r[4] <= $signed(us_dl_r[lat_pkg::UNIT_LAT-1][0]) * $signed(fu[1]);
      xp_r[5] <= $signed(us_dl_r[lat_pkg::UNIT_LAT-1][1]) * $signed(fu[0]);
      for (int i = 0; i < 3; i++) begin
        r_r[i] <= rx_c[i];
      end
    end
  end

  lat_bscale u_bs_r   (.clk(clk), .en(en), .v_in(r_r), .v_out(rs), .nz(rnz));
  lat_unit   u_unit_r (.clk(clk), .en(en), .v_in(rs), .u_out(ru));

  assign deg_v = degb_dl_r[FL-1] || !rnz_dl_r[lat_pkg::UNIT_LAT-1];

  // Local up: forward x right, rounded from Q60 to Q30.
  always_comb begin
    vd_c[0] = vp_r[0] - vp_r[1];
    vd_c[1] = vp_r[2] - vp_r[3];
    vd_c[2] = vp_r[4] - vp_r[5];
    for (int i = 0; i < 3; i++) begin
      vm_c[i] = vd_c[i][63] ? (~vd_c[i] + 64'd1) : vd_c[i];
      vq_c[i] = 34'((vm_c[i] + (64'd1 << 29)) >> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vp_r[0] <= $signed(fu_dl_r[FL-1][1]) * $signed(ru[2]);
      vp_r[1] <= $signed(fu_dl_r[FL-1][2]) * $signed(ru[1]);
      vp_r[2] <= $signed(fu_dl_r[FL-1][2]) * $signed(ru[0]);
      vp_r[3] <= $signed(fu_dl_r[FL-1][0]) * $signed(ru[2]);
      vp_r[4] <= $signed(fu_dl_r[FL-1][0]) * $signed(ru[1]);
      vp_r[5] <= $signed(fu_dl_r[FL-1][1]) * $signed(ru[0]);
      ff_r    <= fu_dl_r[FL-1];
      rr_r    <= ru;
      deg1_r  <= deg_v;
      for (int i = 0; i < 3; i++) begin
        m_r[i]     <= rr_r[i];
        m_r[3 + i] <= vd_c[i][63] ? 32'(~vq_c[i] + 34'd1) : vq_c[i][31:0];
        m_r[6 + i] <= ff_r[i];
      end
      deg2_r <= deg1_r;
    end
  end

  // Branch choice of the trace method.
  always_comb begin
    a00 = 35'(m_r[0]); a01 = 35'(m_r[1]); a02 = 35'(m_r[2]);
    a10 = 35'(m_r[3]); a11 = 35'(m_r[4]); a12 = 35'(m_r[5]);
    a20 = 35'(m_r[6]); a21 = 35'(m_r[7]); a22 = 35'(m_r[8]);
    tr  = a00 + a11 + a22;
    if (tr > 0) begin
      br_c = BR_W;
      t_c  = tr + $signed(lat_pkg::ONE_Q30);
      d_c[0] = a12 - a21; d_c[1] = a20 - a02; d_c[2] = a01 - a10;
    end else if (a00 >= a11 && a00 >= a22) begin
      br_c = BR_X;
      t_c  = $signed(lat_pkg::ONE_Q30) + a00 - a11 - a22;
      d_c[0] = a01 + a10; d_c[1] = a02 + a20; d_c[2] = a12 - a21;
    end else if (a11 > a22) begin
      br_c = BR_Y;
      t_c  = $signed(lat_pkg::ONE_Q30) + a11 - a00 - a22;
      d_c[0] = a10 + a01; d_c[1] = a21 + a12; d_c[2] = a20 - a02;
    end else begin
      br_c = BR_Z;
      t_c  = $signed(lat_pkg::ONE_Q30) + a22 - a00 - a11;
      d_c[0] = a20 + a02; d_c[1] = a21 + a12; d_c[2] = a01 - a10;
    end
    // Keep the root argument at least one step so the divisor is nonzero.
    if (t_c < 1) begin
      t_c = 35'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_arg_r <= {1'b0, t_c[32:0], 30'd0};
      ms_r.br    <= br_c;
      ms_r.deg   <= deg2_r;
      for (int i = 0; i < 3; i++) begin
        ms_r.d[i] <= d_c[i][33:0];
      end
      rs_dl_r[0] <= ms_r;
      for (int k = 1; k < lat_pkg::ISQ_LAT; k++) begin
        rs_dl_r[k] <= rs_dl_r[k-1];
      end
    end
  end

  lat_isqrt u_isqrt (.clk(clk), .en(en), .n_in(root_arg_r), .root(s));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag_c[i] = rs_dl_r[lat_pkg::ISQ_LAT-1].d[i][33]
                  ? (~rs_dl_r[lat_pkg::ISQ_LAT-1].d[i][32:0] + 33'd1)
                  : rs_dl_r[lat_pkg::ISQ_LAT-1].d[i][32:0];
    end
    diag_c = ({1'b0, s} + 33'h10000) >> 17;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i]     <= {16'd0, dmag_c[i], 13'd0} + 62'(s[31:1]);
        cs_r.neg[i]  <= rs_dl_r[lat_pkg::ISQ_LAT-1].d[i][33];
      end
      den_r      <= s;
      cs_r.br    <= rs_dl_r[lat_pkg::ISQ_LAT-1].br;
      cs_r.deg   <= rs_dl_r[lat_pkg::ISQ_LAT-1].deg;
      cs_r.diag  <= diag_c[15:0];
      ds_dl_r[0] <= cs_r;
      for (int k = 1; k < lat_pkg::DIV_LAT; k++) begin
        ds_dl_r[k] <= ds_dl_r[k-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    lat_div u_div (.clk(clk), .en(en), .num(num_r[i]), .den(den_r), .q(q[i]));
  end

  // Sign and saturate the off-diagonal terms, then place them around the
  // diagonal term in x, y, z, w order; a degenerate input gives the identity.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ds_dl_r[lat_pkg::DIV_LAT-1].neg[i]) begin
        off_c[i] = (q[i] >= 31'd32768) ? 16'h8000 : (~q[i][15:0] + 16'd1);
      end else begin
        off_c[i] = (q[i] > 31'd32767) ? 16'h7FFF : q[i][15:0];
      end
    end
    out_c.degenerate = 1'b0;
    out_c.quat_x = off_c[0];
    out_c.quat_y = off_c[1];
    out_c.quat_z = off_c[2];
    out_c.quat_w = 16'(ds_dl_r[lat_pkg::DIV_LAT-1].diag);
    if (ds_dl_r[lat_pkg::DIV_LAT-1].diag > 16'd32767) begin
      out_c.quat_w = 16'h7FFF;
    end
    unique case (ds_dl_r[lat_pkg::DIV_LAT-1].br)
      BR_W: begin
      end
      BR_X: begin
        out_c.quat_x = out_c.quat_w;
        out_c.quat_y = off_c[0];
        out_c.quat_z = off_c[1];
        out_c.quat_w = off_c[2];
      end
      BR_Y: begin
        out_c.quat_y = out_c.quat_w;
        out_c.quat_x = off_c[0];
        out_c.quat_z = off_c[1];
        out_c.quat_w = off_c[2];
      end
      BR_Z: begin
        out_c.quat_z = out_c.quat_w;
        out_c.quat_x = off_c[0];
        out_c.quat_y = off_c[1];
        out_c.quat_w = off_c[2];
      end
      default: begin
      end
    endcase
    if (ds_dl_r[lat_pkg::DIV_LAT-1].deg) begin
      out_c.quat_x     = '0;
      out_c.quat_y     = '0;
      out_c.quat_z     = '0;
      out_c.quat_w     = 16'sd16384;
      out_c.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_c;
    end
  end

  assign out_valid = vld_r[lat_pkg::TOTAL_LAT-1];
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
